>>> hw/rtl/wheel30_prime_sieve_counter_assert.svh
// Assertion macros for the mod-30 wheel prime sieve counter.
// Used by the top level; expects clk and rst_n in scope where expanded.
`ifndef WHEEL30_PRIME_SIEVE_COUNTER_ASSERT_SVH
`define WHEEL30_PRIME_SIEVE_COUNTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define W30_CHECK(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define W30_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/w30ps_pkg.sv
// Package for the mod-30 wheel prime sieve counter: constants, wheel tables,
// microcode word types and the microcode program. No dependencies.
package w30ps_pkg;

    localparam int MAX_BYTES_DEF = 4096;
    localparam int WHEEL         = 30;

    localparam logic [3:0]  NO_SLOT   = 4'd8;
    localparam logic [13:0] COUNT_MAX = 14'h3FFF;
    localparam logic [7:0]  BYTE_ONES = 8'hFF;

    typedef logic [3:0] slot_t;
    typedef logic [4:0] resid_t;

    // Sequencer step addresses.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_PTEST,
        ST_PCHK,
        ST_PADV,
        ST_MTEST,
        ST_MCHK,
        ST_CREAD,
        ST_CACC,
        ST_EMIT
    } step_t;

    // Jump conditions tested by a control word.
    typedef enum logic [2:0] {
        C_ALWAYS,
        C_IN_ACC,
        C_BASE_END,
        C_PSQ_GT,
        C_P_LIVE,
        C_M_GT,
        C_OUT_FREE
    } cond_t;

    // Bitmap read address source.
    typedef enum logic [1:0] {
        RD_BYTE,
        RD_PRIME,
        RD_MULT
    } rd_sel_t;

    typedef struct packed {
        logic    in_ready;
        logic    fill_wr;
        logic    b_clr;
        logic    b_inc;
        logic    p_adv;
        logic    m_init;
        logic    m_wr;
        logic    m_adv;
        logic    c_acc;
        logic    emit;
        rd_sel_t rd_sel;
    } action_t;

    typedef struct packed {
        cond_t   cond;
        step_t   t_step;
        step_t   f_step;
        action_t act;
    } ucode_t;

    // Bit slot of a residue mod 30; NO_SLOT when not coprime to 30.
    function automatic slot_t wheel_slot(input resid_t r);
        slot_t s;
        case (r)
            5'd1:    s = 4'd0;
            5'd7:    s = 4'd1;
            5'd11:   s = 4'd2;
            5'd13:   s = 4'd3;
            5'd17:   s = 4'd4;
            5'd19:   s = 4'd5;
            5'd23:   s = 4'd6;
            5'd29:   s = 4'd7;
            default: s = NO_SLOT;
        endcase
        return s;
    endfunction

    // Residue held by each bit slot of a bitmap byte.
    function automatic resid_t wheel_res(input logic [2:0] i);
        resid_t r;
        case (i)
            3'd0:    r = 5'd1;
            3'd1:    r = 5'd7;
            3'd2:    r = 5'd11;
            3'd3:    r = 5'd13;
            3'd4:    r = 5'd17;
            3'd5:    r = 5'd19;
            3'd6:    r = 5'd23;
            3'd7:    r = 5'd29;
            default: r = 5'd1;
        endcase
        return r;
    endfunction

    // Microcode program: one control word per step.
    function automatic ucode_t ucode_rom(input step_t s);
        ucode_t w;
        w = '0;
        case (s)
            ST_IDLE:
            begin
                w.cond = C_IN_ACC; w.t_step = ST_FILL; w.f_step = ST_IDLE;
                w.act.in_ready = 1'b1;
            end
            ST_FILL:
            begin
                w.cond = C_BASE_END; w.t_step = ST_PTEST; w.f_step = ST_FILL;
                w.act.fill_wr = 1'b1;
                w.act.b_inc   = 1'b1;
            end
            ST_PTEST:
            begin
                w.cond = C_PSQ_GT; w.t_step = ST_CREAD; w.f_step = ST_PCHK;
                w.act.b_clr  = 1'b1;
                w.act.rd_sel = RD_PRIME;
            end
            ST_PCHK:
            begin
                w.cond = C_P_LIVE; w.t_step = ST_MTEST; w.f_step = ST_PADV;
                w.act.m_init = 1'b1;
            end
            ST_PADV:
            begin
                w.cond = C_ALWAYS; w.t_step = ST_PTEST; w.f_step = ST_PTEST;
                w.act.p_adv = 1'b1;
            end
            ST_MTEST:
            begin
                w.cond = C_M_GT; w.t_step = ST_PADV; w.f_step = ST_MCHK;
                w.act.rd_sel = RD_MULT;
            end
            ST_MCHK:
            begin
                w.cond = C_ALWAYS; w.t_step = ST_MTEST; w.f_step = ST_MTEST;
                w.act.m_wr  = 1'b1;
                w.act.m_adv = 1'b1;
            end
            ST_CREAD:
            begin
                w.cond = C_ALWAYS; w.t_step = ST_CACC; w.f_step = ST_CACC;
                w.act.rd_sel = RD_BYTE;
            end
            ST_CACC:
            begin
                w.cond = C_BASE_END; w.t_step = ST_EMIT; w.f_step = ST_CREAD;
                w.act.c_acc = 1'b1;
                w.act.b_inc = 1'b1;
            end
            ST_EMIT:
            begin
                w.cond = C_OUT_FREE; w.t_step = ST_IDLE; w.f_step = ST_EMIT;
                w.act.emit = 1'b1;
            end
            default:
            begin
                w.cond = C_ALWAYS; w.t_step = ST_IDLE; w.f_step = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

>>> hw/rtl/wheel30_prime_sieve_counter.sv
// Mod-30 wheel prime sieve counter: a microcoded sequencer over one bitmap RAM.
// Depends on w30ps_pkg and wheel30_prime_sieve_counter_assert.svh.
// Steps: fill the bitmap, test each odd candidate with p*p <= limit, strike the odd
// multiples of each live one, count the set bits, then emit. One request at a time.
// Reset clears the sequencer and output valid only; the bitmap is refilled per request.
module wheel30_prime_sieve_counter #(
    parameter int MAX_BYTES = w30ps_pkg::MAX_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] limit,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [13:0] num_primes,
    output logic        limit_clamped
);

`include "wheel30_prime_sieve_counter_assert.svh"

    localparam int ADDR_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam int LIM_W  = $clog2(MAX_BYTES * w30ps_pkg::WHEEL);
    localparam int Q_W    = $clog2(2 * MAX_BYTES + 3);
    localparam int VAL_W  = Q_W + 5;
    localparam logic [31:0] CAP_LIMIT = 32'(MAX_BYTES * w30ps_pkg::WHEEL - 1);

    // Sequencer and control word.
    w30ps_pkg::step_t  step_reg, step_next;
    w30ps_pkg::ucode_t uc;
    logic              cond_hit;

    // Datapath registers.
    logic [LIM_W-1:0]  lim_reg, lim_next;
    logic              clamp_reg, clamp_next;
    logic [ADDR_W-1:0] b_reg, b_next;
    logic [VAL_W-1:0]  base_reg, base_next;
    logic [Q_W-1:0]    pq_reg, pq_next, sq_reg, sq_next, dq_reg, dq_next;
    logic [4:0]        pr_reg, pr_next, sr_reg, sr_next, dr_reg, dr_next;
    logic [Q_W-1:0]    mq_reg, mq_next, kq_reg, kq_next;
    logic [4:0]        mr_reg, mr_next, kr_reg, kr_next;
    logic [13:0]       count_reg, count_next;
    logic [13:0]       pc_reg, pc_next;
    logic              lc_reg, lc_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        rd_reg;

    // Bitmap RAM.
    logic [7:0]        mem [MAX_BYTES];
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [7:0]        wr_data;

    // Derived values.
    logic              in_acc, out_free;
    logic [LIM_W-1:0]  ld_lim;
    logic              ld_clamp;
    logic [VAL_W-1:0]  lim_ext, psq_val, m_val;
    logic              base_end;
    w30ps_pkg::slot_t  p_slot, m_slot;
    logic              p_live;
    logic [5:0]        pr_plus, sr_plus, dr_plus, pr_dbl, mr_plus;
    logic              pr_wrap, sr_wrap, dr_wrap, k_wrap, mr_wrap;
    logic [VAL_W-1:0]  n_cand [8];
    logic [7:0]        hit;
    logic [3:0]        pop;
    logic [14:0]       cnt_sum;

    // Handshake and clamped limit.
    assign in_acc   = in_valid && uc.act.in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign ld_clamp = limit > CAP_LIMIT;
    assign ld_lim   = ld_clamp ? LIM_W'(CAP_LIMIT) : LIM_W'(limit);

    // Values rebuilt from (quotient, residue) form by a constant multiply.
    assign lim_ext  = VAL_W'(lim_reg);
    assign psq_val  = VAL_W'(sq_reg) * VAL_W'(w30ps_pkg::WHEEL) + VAL_W'(sr_reg);
    assign m_val    = VAL_W'(mq_reg) * VAL_W'(w30ps_pkg::WHEEL) + VAL_W'(mr_reg);
    assign base_end = (base_reg + VAL_W'(w30ps_pkg::WHEEL)) > lim_ext;

    // Candidate bit test against the byte just read.
    assign p_slot = w30ps_pkg::wheel_slot(pr_reg);
    assign m_slot = w30ps_pkg::wheel_slot(mr_reg);
    assign p_live = (p_slot != w30ps_pkg::NO_SLOT) && rd_reg[p_slot[2:0]];

    // Residue arithmetic mod 30: one compare and subtract per update.
    assign pr_plus = {1'b0, pr_reg} + 6'd2;
    assign pr_wrap = pr_plus >= 6'(w30ps_pkg::WHEEL);
    assign sr_plus = {1'b0, sr_reg} + {1'b0, dr_reg};
    assign sr_wrap = sr_plus >= 6'(w30ps_pkg::WHEEL);
    assign dr_plus = {1'b0, dr_reg} + 6'd8;
    assign dr_wrap = dr_plus >= 6'(w30ps_pkg::WHEEL);
    assign pr_dbl  = {pr_reg, 1'b0};
    assign k_wrap  = pr_dbl >= 6'(w30ps_pkg::WHEEL);
    assign mr_plus = {1'b0, mr_reg} + {1'b0, kr_reg};
    assign mr_wrap = mr_plus >= 6'(w30ps_pkg::WHEEL);

    // Sequencer: fetch the control word and pick the jump target.
    always_comb
    begin
        uc = w30ps_pkg::ucode_rom(step_reg);
        case (uc.cond)
            w30ps_pkg::C_ALWAYS:   cond_hit = 1'b1;
            w30ps_pkg::C_IN_ACC:   cond_hit = in_valid;
            w30ps_pkg::C_BASE_END: cond_hit = base_end;
            w30ps_pkg::C_PSQ_GT:   cond_hit = psq_val > lim_ext;
            w30ps_pkg::C_P_LIVE:   cond_hit = p_live;
            w30ps_pkg::C_M_GT:     cond_hit = m_val > lim_ext;
            w30ps_pkg::C_OUT_FREE: cond_hit = out_free;
            default:               cond_hit = 1'b1;
        endcase
        step_next = cond_hit ? uc.t_step : uc.f_step;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= w30ps_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Per-byte count of set bits that stand for numbers in 2..limit.
    always_comb
    begin
        pop = 4'd0;
        for (int i = 0; i < 8; i++)
        begin
            n_cand[i] = base_reg + VAL_W'(w30ps_pkg::wheel_res(3'(i)));
            hit[i]    = rd_reg[i] && (n_cand[i] > VAL_W'(1)) && (n_cand[i] <= lim_ext);
            pop       = pop + 4'(hit[i]);
        end
    end

    assign cnt_sum = {1'b0, count_reg} + 15'(pop);

    // Datapath next state under the control word's action bits.
    always_comb
    begin
        lim_next       = lim_reg;
        clamp_next     = clamp_reg;
        b_next         = b_reg;
        base_next      = base_reg;
        pq_next        = pq_reg;
        pr_next        = pr_reg;
        sq_next        = sq_reg;
        sr_next        = sr_reg;
        dq_next        = dq_reg;
        dr_next        = dr_reg;
        mq_next        = mq_reg;
        mr_next        = mr_reg;
        kq_next        = kq_reg;
        kr_next        = kr_reg;
        count_next     = count_reg;
        pc_next        = pc_reg;
        lc_next        = lc_reg;
        out_valid_next = out_valid_reg && !out_ready;

        // New request: first candidate is 7, its square 49, next step 4*7+4.
        if (in_acc)
        begin
            lim_next   = ld_lim;
            clamp_next = ld_clamp;
            b_next     = '0;
            base_next  = '0;
            pq_next    = '0;
            pr_next    = 5'd7;
            sq_next    = Q_W'(1);
            sr_next    = 5'd19;
            dq_next    = Q_W'(1);
            dr_next    = 5'd2;
            count_next = 14'(ld_lim >= LIM_W'(2)) + 14'(ld_lim >= LIM_W'(3))
                       + 14'(ld_lim >= LIM_W'(5));
        end

        if (uc.act.b_clr)
        begin
            b_next    = '0;
            base_next = '0;
        end
        if (uc.act.b_inc)
        begin
            b_next    = b_reg + ADDR_W'(1);
            base_next = base_reg + VAL_W'(w30ps_pkg::WHEEL);
        end

        // Next odd candidate, its square and the gap to the next square.
        if (uc.act.p_adv)
        begin
            pr_next = pr_wrap ? 5'(pr_plus - 6'(w30ps_pkg::WHEEL)) : pr_plus[4:0];
            pq_next = pq_reg + Q_W'(pr_wrap);
            sr_next = sr_wrap ? 5'(sr_plus - 6'(w30ps_pkg::WHEEL)) : sr_plus[4:0];
            sq_next = sq_reg + dq_reg + Q_W'(sr_wrap);
            dr_next = dr_wrap ? 5'(dr_plus - 6'(w30ps_pkg::WHEEL)) : dr_plus[4:0];
            dq_next = dq_reg + Q_W'(dr_wrap);
        end

        // First multiple is p*p, stride is 2*p.
        if (uc.act.m_init)
        begin
            mq_next = sq_reg;
            mr_next = sr_reg;
            kr_next = k_wrap ? 5'(pr_dbl - 6'(w30ps_pkg::WHEEL)) : pr_dbl[4:0];
            kq_next = (pq_reg << 1) + Q_W'(k_wrap);
        end
        if (uc.act.m_adv)
        begin
            mr_next = mr_wrap ? 5'(mr_plus - 6'(w30ps_pkg::WHEEL)) : mr_plus[4:0];
            mq_next = mq_reg + kq_reg + Q_W'(mr_wrap);
        end

        if (uc.act.c_acc)
        begin
            count_next = (cnt_sum > 15'(w30ps_pkg::COUNT_MAX)) ? w30ps_pkg::COUNT_MAX
                                                               : cnt_sum[13:0];
        end

        // Result register takes the count once the previous result has left.
        if (uc.act.emit && out_free)
        begin
            pc_next        = count_reg;
            lc_next        = clamp_reg;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        lim_reg   <= lim_next;
        clamp_reg <= clamp_next;
        b_reg     <= b_next;
        base_reg  <= base_next;
        pq_reg    <= pq_next;
        pr_reg    <= pr_next;
        sq_reg    <= sq_next;
        sr_reg    <= sr_next;
        dq_reg    <= dq_next;
        dr_reg    <= dr_next;
        mq_reg    <= mq_next;
        mr_reg    <= mr_next;
        kq_reg    <= kq_next;
        kr_reg    <= kr_next;
        count_reg <= count_next;
        pc_reg    <= pc_next;
        lc_reg    <= lc_next;
    end

    // Bitmap port addressing: fill writes ones, sieve clears one bit.
    always_comb
    begin
        case (uc.act.rd_sel)
            w30ps_pkg::RD_PRIME: rd_addr = pq_reg[ADDR_W-1:0];
            w30ps_pkg::RD_MULT:  rd_addr = mq_reg[ADDR_W-1:0];
            w30ps_pkg::RD_BYTE:  rd_addr = b_reg;
            default:             rd_addr = b_reg;
        endcase
        wr_en   = uc.act.fill_wr || (uc.act.m_wr && (m_slot != w30ps_pkg::NO_SLOT));
        wr_addr = uc.act.m_wr ? mq_reg[ADDR_W-1:0] : b_reg;
        wr_data = uc.act.m_wr ? (rd_reg & ~(8'd1 << m_slot[2:0])) : w30ps_pkg::BYTE_ONES;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_reg <= mem[rd_addr];
    end

    // Ports.
    assign in_ready      = uc.act.in_ready;
    assign out_valid     = out_valid_reg;
    assign num_primes    = pc_reg;
    assign limit_clamped = lc_reg;

    // Checks.
    `W30_CHECK(a_clear_in_range, wr_en && uc.act.m_wr, m_val <= lim_ext, "clear beyond limit")
    `W30_CHECK(a_result_from_emit, $rose(out_valid_reg), $past(step_reg) == w30ps_pkg::ST_EMIT, "result outside emit step")
    `W30_CHECK_NEXT(a_busy_after_request, in_valid && in_ready, !in_ready && step_reg == w30ps_pkg::ST_FILL, "request not followed by fill")

endmodule

>>> test/wheel30_prime_sieve_counter_tb.sv
// Self-checking testbench for the mod-30 wheel prime sieve counter.
// Depends on w30ps_pkg for sizes and constants; drives the block over valid/ready
// and checks each prime count against a behavioral wheel sieve.
module wheel30_prime_sieve_counter_tb;

    localparam int unsigned CAP_LIMIT  = w30ps_pkg::MAX_BYTES_DEF * w30ps_pkg::WHEEL - 1;
    localparam int unsigned IDLE_PCT   = 28;
    localparam int unsigned RAND_ITEMS = 77;
    localparam int unsigned SHOW_MAX   = 10;

    typedef struct {
        logic [31:0] request;
        logic [13:0] count;
        logic        clamped;
    } sieve_result_t;

    // Predicts the prime count of each request and checks the results in order.
    class sieve_scoreboard;
        logic [7:0]     wheel_map [w30ps_pkg::MAX_BYTES_DEF];
        logic [13:0]    last_count;
        int unsigned    coprime_res [8] = '{1, 7, 11, 13, 17, 19, 23, 29};
        sieve_result_t  expected_counts [$];
        int unsigned    failures;

        function new();
            last_count = '0;
            failures   = 0;
        endfunction

        // Bit position of a residue mod 30, or NO_SLOT when it shares a factor with 30.
        function logic [3:0] residue_slot(int unsigned r);
            logic [3:0] s;
            s = w30ps_pkg::NO_SLOT;
            for (int k = 0; k < 8; k++)
            begin
                if (coprime_res[k] == r)
                    s = k[3:0];
            end
            return s;
        endfunction

        function int unsigned pending();
            return expected_counts.size();
        endfunction

        // Runs the wheel sieve for one accepted request and queues the result.
        function void note_request(logic [31:0] req);
            int unsigned   lim;
            int unsigned   blocks;
            int unsigned   p;
            int unsigned   m;
            int unsigned   n;
            int unsigned   cnt;
            logic [3:0]    slot;
            sieve_result_t res;
            res.request = req;
            res.clamped = (req > CAP_LIMIT);
            lim = res.clamped ? CAP_LIMIT : req;
            blocks = lim / w30ps_pkg::WHEEL + 1;
            if (blocks > w30ps_pkg::MAX_BYTES_DEF)
                blocks = w30ps_pkg::MAX_BYTES_DEF;
            for (int b = 0; b < blocks; b++)
                wheel_map[b] = w30ps_pkg::BYTE_ONES;

            // Strike odd multiples of each surviving candidate, starting at its square.
            for (p = 7; p * p <= lim; p += 2)
            begin
                slot = residue_slot(p % w30ps_pkg::WHEEL);
                if (slot == w30ps_pkg::NO_SLOT)
                    continue;
                if (!wheel_map[p / w30ps_pkg::WHEEL][slot[2:0]])
                    continue;
                for (m = p * p; m <= lim; m += 2 * p)
                begin
                    slot = residue_slot(m % w30ps_pkg::WHEEL);
                    if (slot != w30ps_pkg::NO_SLOT)
                        wheel_map[m / w30ps_pkg::WHEEL][slot[2:0]] = 1'b0;
                end
            end

            // Count survivors in 2..lim, plus the wheel primes 2, 3 and 5.
            cnt = 0;
            if (lim >= 2) cnt++;
            if (lim >= 3) cnt++;
            if (lim >= 5) cnt++;
            for (int b = 0; b < blocks; b++)
            begin
                for (int k = 0; k < 8; k++)
                begin
                    n = b * w30ps_pkg::WHEEL + coprime_res[k];
                    if (n <= 1 || n > lim)
                        continue;
                    if (wheel_map[b][k] && cnt < w30ps_pkg::COUNT_MAX)
                        cnt++;
                end
            end
            last_count = cnt[13:0];
            res.count  = last_count;
            expected_counts.push_back(res);
        endfunction

        function void report_mismatch(string what);
            failures++;
            if (failures <= SHOW_MAX)
                $display("%t: %s", $realtime, what);
        endfunction

        // Compares one accepted result with the oldest expectation.
        function void check_result(logic [13:0] cnt, logic clp);
            sieve_result_t e;
            if (expected_counts.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result count=%0d clamped=%0b", cnt, clp));
                return;
            end
            e = expected_counts.pop_front();
            if (cnt !== e.count)
                report_mismatch($sformatf("limit %0d: num_primes expected %0d, got %0d",
                                          e.request, e.count, cnt));
            if (clp !== e.clamped)
                report_mismatch($sformatf("limit %0d: limit_clamped expected %0b, got %0b",
                                          e.request, e.clamped, clp));
        endfunction
    endclass

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [31:0] limit     = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [13:0] num_primes;
    logic        limit_clamped;

    bit              steady_phase = 1'b0;
    sieve_scoreboard sieve_sb = new();

    wheel30_prime_sieve_counter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .limit         (limit),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .num_primes    (num_primes),
        .limit_clamped (limit_clamped)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // The receiver stalls at random except during the steady stretch.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= steady_phase || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Every accepted result goes to the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sieve_sb.check_result(num_primes, limit_clamped);
    end

    // Offers one request after an optional random gap and waits for acceptance.
    task automatic send_request(input logic [31:0] value);
        while (!steady_phase && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        limit    <= value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sieve_sb.note_request(value);
    endtask

    // Holds the sender off until every queued result has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sieve_sb.pending() != 0);
    endtask

    initial
    begin
        logic [31:0] directed_limits [$];
        int unsigned big_at;
        int unsigned pick;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests: tiny limits, wheel edges, first squares and the capacity edge.
        directed_limits = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 29, 30, 31, 48, 49, 119, 120, 121,
                            169, 1000, 30000, CAP_LIMIT, CAP_LIMIT + 1, 32'hFFFF_FFFF};
        foreach (directed_limits[k])
            send_request(directed_limits[k]);
        drain_results();

        // Random requests: mostly small limits, with one full-width value.
        big_at = $urandom_range(0, RAND_ITEMS - 1);
        for (int k = 0; k < RAND_ITEMS; k++)
        begin
            steady_phase = (k >= 40 && k < 60);
            if (k == 75)
                drain_results();
            pick = $urandom_range(0, 99);
            if (k == big_at)
                send_request($urandom());
            else if (pick < 80)
                send_request($urandom_range(0, 1000));
            else if (pick < 97)
                send_request($urandom_range(1001, 6000));
            else
                send_request($urandom_range(6001, 20000));
        end
        steady_phase = 1'b0;
        drain_results();
        repeat (64) @(posedge clk);

        if (sieve_sb.failures == 0 && sieve_sb.pending() == 0)
            $display("wheel30_prime_sieve_counter: match");
        else
            $display("wheel30_prime_sieve_counter: mismatch");
        $finish;
    end

    // Watchdog: several times the slowest expected run.
    initial
    begin
        #40_000_000;
        $display("wheel30_prime_sieve_counter: mismatch");
        $finish;
    end

endmodule
